>>> sv/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

   localparam int MAX_SLICES   = 360;
   localparam int SLICES_W     = 9;
   localparam int PAR_W        = 8;
   localparam int RADIUS_W     = 16;
   localparam int POS_W        = 17;
   localparam int TEX_W        = 17;
   localparam int TRI_W        = 16;
   localparam int PHASE_W      = 32;
   localparam int TAB_AW       = 9;
   localparam int TAB_DEPTH    = 1 << TAB_AW;
   localparam int DIV_W        = 33;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_XW    = 34;
   localparam int UNIT_W       = 32;
   // cordic: one input stage, one stage per step, one clamp/quadrant stage
   localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
   // side fields ride from the stage after the table read to the output
   localparam int SIDE_DEPTH   = CORDIC_LAT + 2;

   localparam logic signed [CORDIC_XW-1:0] CORDIC_K = 34'sd652032874;
   localparam logic signed [CORDIC_XW-1:0] ONE_Q30  = 34'sd1073741824;
   localparam logic [TEX_W-1:0]            TEX_ONE  = 17'd65536;

   localparam logic [SLICES_W-1:0] SLICES_RESET = 9'd20;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICES = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS = 1'b1;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
   } entry_type;

   typedef struct packed {
      logic [PHASE_W-1:0] phase_i;
      logic [PHASE_W-1:0] phase_j;
      logic [TEX_W-1:0]   tex_u;
      logic [TEX_W-1:0]   tex_v;
   } rd_type;

   typedef struct packed {
      logic             valid;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
      logic [TRI_W-1:0] base0;
      logic [TRI_W-1:0] base1;
      logic [TRI_W-1:0] base0_p1;
      logic [TRI_W-1:0] base1_p1;
      logic             quad;
   } side_type;

   function automatic logic signed [CORDIC_XW-1:0] atan_turn(input logic [4:0] k);
      logic signed [CORDIC_XW-1:0] a;
      unique case (k)
         5'd0:  a = 34'sd536870912;
         5'd1:  a = 34'sd316933405;
         5'd2:  a = 34'sd167458907;
         5'd3:  a = 34'sd85004756;
         5'd4:  a = 34'sd42667331;
         5'd5:  a = 34'sd21354465;
         5'd6:  a = 34'sd10680862;
         5'd7:  a = 34'sd5340245;
         5'd8:  a = 34'sd2670675;
         5'd9:  a = 34'sd1335342;
         5'd10: a = 34'sd667544;
         5'd11: a = 34'sd333772;
         5'd12: a = 34'sd166886;
         5'd13: a = 34'sd83443;
         5'd14: a = 34'sd41721;
         5'd15: a = 34'sd20860;
         5'd16: a = 34'sd10430;
         5'd17: a = 34'sd5215;
         5'd18: a = 34'sd2607;
         5'd19: a = 34'sd1303;
         5'd20: a = 34'sd651;
         5'd21: a = 34'sd325;
         5'd22: a = 34'sd162;
         5'd23: a = 34'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

>>> sv/uvs_div.sv
`default_nettype none
module uvs_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [uvs_pkg::DIV_W-1:0]     dividend,
   input  wire logic [uvs_pkg::SLICES_W-1:0]  divisor,
   output logic                               done,
   output logic [uvs_pkg::DIV_W-1:0]          quot,
   output logic [uvs_pkg::SLICES_W-1:0]       rem
);

   logic                          run_ff, run_in;
   logic                          done_ff, done_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic [uvs_pkg::DIV_W-1:0]     quot_ff, quot_in;
   logic [uvs_pkg::SLICES_W-1:0]  rem_ff, rem_in;
   logic [uvs_pkg::SLICES_W-1:0]  div_ff, div_in;
   logic [uvs_pkg::SLICES_W:0]    trial;
   logic                          fits;

   assign trial = {rem_ff, quot_ff[uvs_pkg::DIV_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (go) begin
         run_in  = 1'b1;
         cnt_in  = 6'(uvs_pkg::DIV_W);
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (run_ff) begin
         // shift one dividend bit in, subtract when it fits
         quot_in = {quot_ff[uvs_pkg::DIV_W-2:0], fits};
         rem_in  = fits ? uvs_pkg::SLICES_W'(trial - {1'b0, div_ff})
                        : trial[uvs_pkg::SLICES_W-1:0];
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

>>> sv/uvs_table.sv
`default_nettype none
module uvs_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          restart,
   input  wire logic [uvs_pkg::SLICES_W-1:0]  slices,
   input  wire logic [uvs_pkg::PAR_W-1:0]     addr_i,
   input  wire logic [uvs_pkg::TAB_AW-1:0]    addr_j,
   output logic                               busy,
   output uvs_pkg::rd_type                    rd
);

   typedef enum logic [3:0] {
      ST_START = 4'b0001,
      ST_DIV   = 4'b0010,
      ST_FILL  = 4'b0100,
      ST_READY = 4'b1000
   } state_type;

   localparam int ACC_W = 25;

   state_type state_ff, state_in;

   logic [uvs_pkg::SLICES_W-1:0] pars;
   logic [uvs_pkg::SLICES_W-1:0] half_s, half_p;
   logic                         go;
   logic [2:0]                   done;
   logic [uvs_pkg::DIV_W-1:0]    quot_p, quot_u, quot_v;
   logic [uvs_pkg::SLICES_W-1:0] rem_p, rem_u, rem_v;

   logic [uvs_pkg::TAB_AW-1:0]   k_ff, k_in;
   logic [uvs_pkg::SLICES_W-1:0] m_ff, m_in;
   logic [uvs_pkg::PHASE_W-1:0]  qp_ff, qp_in;
   logic [ACC_W-1:0]             qu_ff, qu_in, qv_ff, qv_in;
   logic [uvs_pkg::SLICES_W-1:0] rp_ff, rp_in, ru_ff, ru_in, rv_ff, rv_in;
   logic [uvs_pkg::SLICES_W:0]   tp, tu, tv;
   logic                         cp, cu, cv;
   uvs_pkg::entry_type           wr_entry;

   uvs_pkg::entry_type mem [uvs_pkg::TAB_DEPTH];
   uvs_pkg::entry_type rd_i_ff, rd_j_ff;

   assign pars   = {1'b0, slices[uvs_pkg::SLICES_W-1:1]};
   assign half_s = {1'b0, slices[uvs_pkg::SLICES_W-1:1]};
   assign half_p = {1'b0, pars[uvs_pkg::SLICES_W-1:1]};
   assign go     = (state_ff == ST_START);

   uvs_div u_div_p (
      .clock, .reset, .go,
      .dividend(uvs_pkg::DIV_W'(64'd1 << 32)), .divisor(slices),
      .done(done[0]), .quot(quot_p), .rem(rem_p)
   );
   uvs_div u_div_u (
      .clock, .reset, .go,
      .dividend(uvs_pkg::DIV_W'(64'd1 << 16)), .divisor(slices),
      .done(done[1]), .quot(quot_u), .rem(rem_u)
   );
   uvs_div u_div_v (
      .clock, .reset, .go,
      .dividend(uvs_pkg::DIV_W'(64'd1 << 16)), .divisor(pars),
      .done(done[2]), .quot(quot_v), .rem(rem_v)
   );

   // carry the fractional part of each running quotient
   assign tp = {1'b0, rp_ff} + {1'b0, rem_p};
   assign tu = {1'b0, ru_ff} + {1'b0, rem_u};
   assign tv = {1'b0, rv_ff} + {1'b0, rem_v};
   assign cp = tp >= {1'b0, slices};
   assign cu = tu >= {1'b0, slices};
   assign cv = tv >= {1'b0, pars};

   always_comb begin
      wr_entry.phase = qp_ff;
      wr_entry.tex_u = (qu_ff > ACC_W'(uvs_pkg::TEX_ONE)) ? uvs_pkg::TEX_ONE
                                                          : qu_ff[uvs_pkg::TEX_W-1:0];
      wr_entry.tex_v = ({1'b0, k_ff} < {1'b0, pars})
                     ? uvs_pkg::TEX_W'(uvs_pkg::TEX_ONE - qv_ff[uvs_pkg::TEX_W-1:0])
                     : '0;
   end

   always_comb begin
      state_in = state_ff;
      k_in  = k_ff;   m_in  = m_ff;
      qp_in = qp_ff;  rp_in = rp_ff;
      qu_in = qu_ff;  ru_in = ru_ff;
      qv_in = qv_ff;  rv_in = rv_ff;
      unique case (state_ff)
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (&done) begin
               state_in = ST_FILL;
               k_in  = '0;  m_in  = '0;
               qp_in = '0;  rp_in = half_s;
               qu_in = '0;  ru_in = half_s;
               qv_in = '0;  rv_in = half_p;
            end
         end
         ST_FILL: begin
            k_in  = k_ff + 1'b1;
            qu_in = qu_ff + ACC_W'(quot_u[uvs_pkg::TEX_W-1:0]) + ACC_W'(cu);
            ru_in = cu ? uvs_pkg::SLICES_W'(tu - {1'b0, slices}) : tu[uvs_pkg::SLICES_W-1:0];
            qv_in = qv_ff + ACC_W'(quot_v[uvs_pkg::TEX_W-1:0]) + ACC_W'(cv);
            rv_in = cv ? uvs_pkg::SLICES_W'(tv - {1'b0, pars}) : tv[uvs_pkg::SLICES_W-1:0];
            if (m_ff + 1'b1 == slices) begin
               // phase restarts each full turn
               m_in  = '0;
               qp_in = '0;
               rp_in = half_s;
            end else begin
               m_in  = m_ff + 1'b1;
               qp_in = qp_ff + quot_p[uvs_pkg::PHASE_W-1:0] + uvs_pkg::PHASE_W'(cp);
               rp_in = cp ? uvs_pkg::SLICES_W'(tp - {1'b0, slices})
                          : tp[uvs_pkg::SLICES_W-1:0];
            end
            if (&k_ff) state_in = ST_READY;
         end
         ST_READY: state_in = ST_READY;
         default:  state_in = ST_START;
      endcase
      if (restart) state_in = ST_START;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_START;
      else       state_ff <= state_in;
      k_ff  <= k_in;   m_ff  <= m_in;
      qp_ff <= qp_in;  rp_ff <= rp_in;
      qu_ff <= qu_in;  ru_ff <= ru_in;
      qv_ff <= qv_in;  rv_ff <= rv_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) mem[k_ff] <= wr_entry;
      rd_i_ff <= mem[{1'b0, addr_i}];
      rd_j_ff <= mem[addr_j];
   end

   assign busy       = (state_ff != ST_READY);
   assign rd.phase_i = rd_i_ff.phase;
   assign rd.phase_j = rd_j_ff.phase;
   assign rd.tex_u   = rd_j_ff.tex_u;
   assign rd.tex_v   = rd_i_ff.tex_v;

endmodule
`default_nettype wire

>>> sv/uvs_cordic.sv
`default_nettype none
module uvs_cordic (
   input  wire logic                          clock,
   input  wire logic [uvs_pkg::PHASE_W-1:0]   phase,
   output logic signed [uvs_pkg::UNIT_W-1:0]  cos_out,
   output logic signed [uvs_pkg::UNIT_W-1:0]  sin_out
);

   localparam int N = uvs_pkg::CORDIC_STEPS;
   localparam int W = uvs_pkg::CORDIC_XW;

   logic signed [W-1:0] x_ff [N+1];
   logic signed [W-1:0] y_ff [N+1];
   logic signed [W-1:0] z_ff [N+1];
   logic [1:0]          q_ff [N+1];
   logic signed [uvs_pkg::UNIT_W-1:0] cos_ff, sin_ff, cx, cy;

   function automatic logic signed [uvs_pkg::UNIT_W-1:0] clamp_unit(
      input logic signed [W-1:0] v);
      logic signed [W-1:0] c;
      if (v > uvs_pkg::ONE_Q30)       c = uvs_pkg::ONE_Q30;
      else if (v < -uvs_pkg::ONE_Q30) c = -uvs_pkg::ONE_Q30;
      else                            c = v;
      return c[uvs_pkg::UNIT_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      x_ff[0] <= uvs_pkg::CORDIC_K;
      y_ff[0] <= '0;
      z_ff[0] <= W'(phase[29:0]);
      q_ff[0] <= phase[31:30];
   end

   for (genvar k = 0; k < N; k++) begin : g_step
      logic signed [W-1:0] dx, dy, a;
      assign dx = y_ff[k] >>> k;
      assign dy = x_ff[k] >>> k;
      assign a  = uvs_pkg::atan_turn(5'(k));
      always_ff @(posedge clock) begin
         if (z_ff[k] >= 0) begin
            x_ff[k+1] <= x_ff[k] - dx;
            y_ff[k+1] <= y_ff[k] + dy;
            z_ff[k+1] <= z_ff[k] - a;
         end else begin
            x_ff[k+1] <= x_ff[k] + dx;
            y_ff[k+1] <= y_ff[k] - dy;
            z_ff[k+1] <= z_ff[k] + a;
         end
         q_ff[k+1] <= q_ff[k];
      end
   end

   assign cx = clamp_unit(x_ff[N]);
   assign cy = clamp_unit(y_ff[N]);

   // fold the quarter-turn result back into its quadrant
   always_ff @(posedge clock) begin
      unique case (q_ff[N])
         2'd0: begin cos_ff <= cx;  sin_ff <= cy;  end
         2'd1: begin cos_ff <= -cy; sin_ff <= cx;  end
         2'd2: begin cos_ff <= -cx; sin_ff <= -cy; end
         default: begin cos_ff <= cy; sin_ff <= -cx; end
      endcase
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule
`default_nettype wire

>>> sv/uv_sphere_mesh_point_top.sv
`default_nettype none
// UV sphere grid point generator. Pulse start with a parallel and slice index
// while busy is low; the vertex, texture coordinate and quad indices come
// back on the rsp_ ports, flagged by rsp_valid for exactly one cycle. One
// item per cycle is taken while busy is low; the result side has no
// back-pressure, so take every strobe. After reset and after each write of
// the slices register, busy stays high through a start state, a run of
// three parallel bit-serial dividers, then a 512-entry sweep that fills
// the phase / texture table one entry a cycle. Radius writes take effect at
// once. Write configuration only when no item is in flight.
module uv_sphere_mesh_point_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [uvs_pkg::PAR_W-1:0]            req_parallel_index,
   input  wire logic [uvs_pkg::SLICES_W-1:0]         req_slice_index,
   input  wire logic                                 csr_write_en,
   input  wire logic [uvs_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [uvs_pkg::RADIUS_W-1:0]         csr_wdata,
   output logic                                      rsp_valid,
   output logic signed [uvs_pkg::POS_W-1:0]          rsp_pos_x,
   output logic signed [uvs_pkg::POS_W-1:0]          rsp_pos_y,
   output logic signed [uvs_pkg::POS_W-1:0]          rsp_pos_z,
   output logic [uvs_pkg::TEX_W-1:0]                 rsp_tex_u,
   output logic [uvs_pkg::TEX_W-1:0]                 rsp_tex_v,
   output logic [uvs_pkg::TRI_W-1:0]                 rsp_tri_a0,
   output logic [uvs_pkg::TRI_W-1:0]                 rsp_tri_a1,
   output logic [uvs_pkg::TRI_W-1:0]                 rsp_tri_a2,
   output logic [uvs_pkg::TRI_W-1:0]                 rsp_tri_b0,
   output logic [uvs_pkg::TRI_W-1:0]                 rsp_tri_b1,
   output logic [uvs_pkg::TRI_W-1:0]                 rsp_tri_b2,
   output logic                                      rsp_quad_valid
);

   localparam int SW = uvs_pkg::SLICES_W;
   localparam logic signed [63:0] HALF_Q30 = 64'sd536870912;

   logic [SW-1:0]                slices_ff;
   logic [uvs_pkg::RADIUS_W-1:0] radius_ff;
   logic [SW-1:0]                wr_slices, clamp_slices, pars;
   logic                         accept, restart;

   // configuration: slices is kept already clamped to its legal range
   assign wr_slices    = csr_wdata[SW-1:0];
   assign clamp_slices = (wr_slices < SW'(2)) ? SW'(2)
                       : (wr_slices > SW'(uvs_pkg::MAX_SLICES)) ? SW'(uvs_pkg::MAX_SLICES)
                       : wr_slices;
   assign restart = csr_write_en && (csr_index == uvs_pkg::CSR_SLICES);
   assign pars    = {1'b0, slices_ff[SW-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= uvs_pkg::SLICES_RESET;
         radius_ff <= uvs_pkg::RADIUS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            uvs_pkg::CSR_SLICES: slices_ff <= clamp_slices;
            uvs_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept = start && !busy;

   // stage 1: table read, hold indices alongside
   uvs_pkg::rd_type      rd;
   logic                 v1_ff;
   logic [uvs_pkg::PAR_W-1:0] i1_ff;
   logic [SW-1:0]        j1_ff;

   uvs_table u_table (
      .clock, .reset, .restart,
      .slices(slices_ff),
      .addr_i(req_parallel_index),
      .addr_j(req_slice_index),
      .busy, .rd
   );

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
      i1_ff <= req_parallel_index;
      j1_ff <= req_slice_index;
   end

   // stage 2: quad indices and flag, then ride along with the trig pipe
   uvs_pkg::side_type side_in;
   uvs_pkg::side_type side_ff [uvs_pkg::SIDE_DEPTH];
   logic [SW:0]  width_row;
   logic [18:0]  base0_w;

   assign width_row = {1'b0, slices_ff} + 1'b1;
   assign base0_w   = 19'(i1_ff) * 19'(width_row) + 19'(j1_ff);

   always_comb begin
      side_in.valid    = v1_ff;
      side_in.tex_u    = rd.tex_u;
      side_in.tex_v    = rd.tex_v;
      side_in.base0    = base0_w[uvs_pkg::TRI_W-1:0];
      side_in.base1    = uvs_pkg::TRI_W'(base0_w + 19'(width_row));
      side_in.base0_p1 = uvs_pkg::TRI_W'(base0_w + 19'd1);
      side_in.base1_p1 = uvs_pkg::TRI_W'(base0_w + 19'(width_row) + 19'd1);
      side_in.quad     = ({1'b0, i1_ff} < pars) && (j1_ff < slices_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < uvs_pkg::SIDE_DEPTH; n++) side_ff[n].valid <= 1'b0;
      end else begin
         side_ff[0].valid <= side_in.valid;
         for (int n = 1; n < uvs_pkg::SIDE_DEPTH; n++)
            side_ff[n].valid <= side_ff[n-1].valid;
      end
      side_ff[0].tex_u    <= side_in.tex_u;
      side_ff[0].tex_v    <= side_in.tex_v;
      side_ff[0].base0    <= side_in.base0;
      side_ff[0].base1    <= side_in.base1;
      side_ff[0].base0_p1 <= side_in.base0_p1;
      side_ff[0].base1_p1 <= side_in.base1_p1;
      side_ff[0].quad     <= side_in.quad;
      for (int n = 1; n < uvs_pkg::SIDE_DEPTH; n++) begin
         side_ff[n].tex_u    <= side_ff[n-1].tex_u;
         side_ff[n].tex_v    <= side_ff[n-1].tex_v;
         side_ff[n].base0    <= side_ff[n-1].base0;
         side_ff[n].base1    <= side_ff[n-1].base1;
         side_ff[n].base0_p1 <= side_ff[n-1].base0_p1;
         side_ff[n].base1_p1 <= side_ff[n-1].base1_p1;
         side_ff[n].quad     <= side_ff[n-1].quad;
      end
   end

   // stages 2..27: sine and cosine of both angles
   logic signed [uvs_pkg::UNIT_W-1:0] ci, si, cj, sj;

   uvs_cordic u_cordic_i (.clock, .phase(rd.phase_i), .cos_out(ci), .sin_out(si));
   uvs_cordic u_cordic_j (.clock, .phase(rd.phase_j), .cos_out(cj), .sin_out(sj));

   // stage 28: products of unit values, rounded half up back to Q2.30
   logic signed [63:0] mx, mz, ry;
   logic signed [uvs_pkg::UNIT_W-1:0] ux_ff, uz_ff, uy_ff;
   logic signed [uvs_pkg::UNIT_W-1:0] ux_in, uz_in;

   assign mx    = si * sj;
   assign mz    = si * cj;
   assign ux_in = uvs_pkg::UNIT_W'((mx + HALF_Q30) >>> 30);
   assign uz_in = uvs_pkg::UNIT_W'((mz + HALF_Q30) >>> 30);

   always_ff @(posedge clock) begin
      ux_ff <= ux_in;
      uz_ff <= uz_in;
      uy_ff <= ci;
   end

   // stage 29: scale by the radius into Q9.8
   logic signed [uvs_pkg::RADIUS_W:0] rad_s;
   logic signed [63:0] px, pz;
   logic signed [uvs_pkg::POS_W-1:0] px_ff, py_ff, pz_ff;

   assign rad_s = {1'b0, radius_ff};
   assign px    = rad_s * ux_ff;
   assign pz    = rad_s * uz_ff;
   assign ry    = rad_s * uy_ff;

   always_ff @(posedge clock) begin
      px_ff <= uvs_pkg::POS_W'((px + HALF_Q30) >>> 30);
      py_ff <= uvs_pkg::POS_W'((ry + HALF_Q30) >>> 30);
      pz_ff <= uvs_pkg::POS_W'((pz + HALF_Q30) >>> 30);
   end

   localparam int LAST = uvs_pkg::SIDE_DEPTH - 1;

   assign rsp_valid      = side_ff[LAST].valid;
   assign rsp_pos_x      = px_ff;
   assign rsp_pos_y      = py_ff;
   assign rsp_pos_z      = pz_ff;
   assign rsp_tex_u      = side_ff[LAST].tex_u;
   assign rsp_tex_v      = side_ff[LAST].tex_v;
   assign rsp_tri_a0     = side_ff[LAST].base0;
   assign rsp_tri_a1     = side_ff[LAST].base1;
   assign rsp_tri_a2     = side_ff[LAST].base1_p1;
   assign rsp_tri_b0     = side_ff[LAST].base0;
   assign rsp_tri_b1     = side_ff[LAST].base1_p1;
   assign rsp_tri_b2     = side_ff[LAST].base0_p1;
   assign rsp_quad_valid = side_ff[LAST].quad;

endmodule
`default_nettype wire
